>>> rtl/task_watchdog_slot_table_assert.svh
// ----------------------------------------------------------------------------
// Watchdog slot table assertion macros
// Shorthand for the concurrent checks of the watchdog slot table.
// ----------------------------------------------------------------------------
`ifndef TASK_WATCHDOG_SLOT_TABLE_ASSERT_SVH
`define TASK_WATCHDOG_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TWD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define TWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/twd_pkg.sv
// ----------------------------------------------------------------------------
// Watchdog slot table package
// Request, response and slot record types, opcodes and scan states.
// ----------------------------------------------------------------------------
package twd_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int SLOT_W        = 6;
   localparam int TIME_W        = 32;
   localparam int STEP_W        = 8;
   localparam int OP_W          = 3;
   localparam int MASK_W        = 16;
   localparam int MASK_IDX_W    = $clog2(MASK_W);

   localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_ENTER  = 3'd2;
   localparam logic [OP_W-1:0] OP_EXIT   = 3'd3;
   localparam logic [OP_W-1:0] OP_CHECK  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] now_time;
      logic [TIME_W-1:0] timeout_limit;
      logic [STEP_W-1:0] step_tag;
      logic              name_given;
   } twd_req_type;

   typedef struct packed {
      logic              status;
      logic [SLOT_W-1:0] slot_out;
      logic [MASK_W-1:0] expired_mask;
   } twd_rsp_type;

   // One watchdog slot as it travels around the ring
   typedef struct packed {
      logic              used;
      logic              active;
      logic [STEP_W-1:0] step;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] timeout;
   } twd_rec_type;

   // Control from the sequencer to the head unit
   typedef struct packed {
      logic              start;
      logic              scan;
      logic [SLOT_W-1:0] idx;
   } twd_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } twd_state_type;

endpackage

>>> rtl/task_watchdog_slot_table.sv
// ----------------------------------------------------------------------------
// Task watchdog slot table
// Each request is accepted in the idle state; in the scan state the slot
// records then rotate once around a ring of cells past the head unit (one
// slot per cycle, one 32-bit subtract and compare for the timeout check),
// and in the done state the response register is loaded. The next request
// is accepted while a response still waits to be taken; the load in the
// done state stalls for as long as an earlier response is held off.
// ----------------------------------------------------------------------------
module task_watchdog_slot_table #(
   parameter int NUM_SLOTS = twd_pkg::NUM_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  twd_pkg::twd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output twd_pkg::twd_rsp_type rsp_data
);

   `include "task_watchdog_slot_table_assert.svh"

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   twd_pkg::twd_state_type state_ff;
   twd_pkg::twd_state_type state_in;
   logic [IDX_W-1:0]       cnt_ff;
   logic [IDX_W-1:0]       cnt_in;
   twd_pkg::twd_req_type   req_ff;
   logic                   rsp_valid_ff;
   twd_pkg::twd_rsp_type   rsp_data_ff;
   logic                   accept;
   logic                   scan;
   logic                   last;
   logic                   load_rsp;
   twd_pkg::twd_ctl_type   ctl;
   twd_pkg::twd_rec_type   head_rec_out;
   twd_pkg::twd_rsp_type   head_rsp;
   twd_pkg::twd_rec_type   ring [NUM_SLOTS];

   assign accept = req_valid && req_ready;
   assign last   = (cnt_ff == IDX_W'(NUM_SLOTS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twd_pkg::ST_IDLE: if (req_valid) state_in = twd_pkg::ST_SCAN;
         twd_pkg::ST_SCAN: if (last) state_in = twd_pkg::ST_DONE;
         twd_pkg::ST_DONE: if (!rsp_valid_ff || rsp_ready) state_in = twd_pkg::ST_IDLE;
         default:          state_in = twd_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      scan      = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         twd_pkg::ST_IDLE: req_ready = 1'b1;
         twd_pkg::ST_SCAN: scan = 1'b1;
         twd_pkg::ST_DONE: load_rsp = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // Advance the slot counter through the scan, wrap to zero at the end
   always_comb begin
      cnt_in = cnt_ff;
      if (scan) begin
         cnt_in = last ? '0 : cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Hold the accepted request for the whole scan
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= head_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ctl.start = accept;
   assign ctl.scan  = scan;
   assign ctl.idx   = twd_pkg::SLOT_W'(cnt_ff);

   // Head unit sees the record in cell 0 and feeds the last cell
   twd_head u_head (
      .clock   (clock),
      .ctl     (ctl),
      .req     (req_ff),
      .rec_in  (ring[0]),
      .rec_out (head_rec_out),
      .rsp     (head_rsp)
   );

   // Ring of slot cells
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      twd_pkg::twd_rec_type cell_in;
      if (i == NUM_SLOTS - 1) begin : g_tail
         assign cell_in = head_rec_out;
      end else begin : g_link
         assign cell_in = ring[i+1];
      end
      twd_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (scan),
         .rec_in  (cell_in),
         .rec_out (ring[i])
      );
   end

   `TWD_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_valid && req_ready,
      state_ff == twd_pkg::ST_SCAN, "accepted request did not start a scan")
   `TWD_ASSERT_IMP(a_ring_aligned, clock, reset, state_ff != twd_pkg::ST_SCAN,
      cnt_ff == '0, "slot ring not aligned outside a scan")
   `TWD_ASSERT_IMP(a_slot_out_success, clock, reset, rsp_valid && (rsp_data.slot_out != '0),
      rsp_data.status == 1'b0, "slot returned with a failing status")
   `TWD_ASSERT_IMP(a_mask_fails, clock, reset, rsp_valid && (rsp_data.expired_mask != '0),
      rsp_data.status == 1'b1, "expired slots reported with a passing status")

endmodule

>>> rtl/twd_cell.sv
// ----------------------------------------------------------------------------
// Watchdog slot cell
// Holds one slot record and passes it to its neighbor on every scan cycle.
// ----------------------------------------------------------------------------
module twd_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  twd_pkg::twd_rec_type rec_in,
   output twd_pkg::twd_rec_type rec_out
);

   twd_pkg::twd_rec_type rec_ff;

   // Advance the record one place along the ring
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else if (shift) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_out = rec_ff;

endmodule

>>> rtl/twd_head.sv
// ----------------------------------------------------------------------------
// Watchdog slot head unit
// Inspects and rewrites the slot record at the ring head, gathers the result.
// ----------------------------------------------------------------------------
module twd_head (
   input  logic                 clock,
   input  twd_pkg::twd_ctl_type ctl,
   input  twd_pkg::twd_req_type req,
   input  twd_pkg::twd_rec_type rec_in,
   output twd_pkg::twd_rec_type rec_out,
   output twd_pkg::twd_rsp_type rsp
);

   logic                                 flag_ff;
   logic                                 flag_in;
   logic [twd_pkg::SLOT_W-1:0]           slot_out_ff;
   logic [twd_pkg::SLOT_W-1:0]           slot_out_in;
   logic [twd_pkg::MASK_W-1:0]           mask_ff;
   logic [twd_pkg::MASK_W-1:0]           mask_in;
   logic                                 match;
   logic                                 expired;
   logic [twd_pkg::TIME_W-1:0]           elapsed;

   assign match   = (ctl.idx == req.slot) && rec_in.used;
   assign elapsed = req.now_time - rec_in.stamp;
   assign expired = rec_in.used && (elapsed >= rec_in.timeout);

   // Rewrite the head record and update the running flags
   always_comb begin
      rec_out     = rec_in;
      flag_in     = flag_ff;
      slot_out_in = slot_out_ff;
      mask_in     = mask_ff;
      unique case (req.opcode)
         twd_pkg::OP_CREATE: begin
            if (!flag_ff && !rec_in.used && req.name_given) begin
               rec_out.used    = 1'b1;
               rec_out.active  = 1'b0;
               rec_out.step    = '0;
               rec_out.stamp   = req.now_time;
               rec_out.timeout = req.timeout_limit;
               flag_in         = 1'b1;
               slot_out_in     = ctl.idx;
            end
         end
         twd_pkg::OP_DELETE: begin
            if (match) begin
               rec_out = '0;
            end
         end
         twd_pkg::OP_ENTER: begin
            if (match) begin
               rec_out.stamp  = req.now_time;
               rec_out.step   = req.step_tag;
               rec_out.active = 1'b1;
               flag_in        = 1'b1;
            end
         end
         twd_pkg::OP_EXIT: begin
            if (match) begin
               rec_out.active = 1'b0;
               flag_in        = 1'b1;
            end
         end
         twd_pkg::OP_CHECK: begin
            if (expired) begin
               flag_in = 1'b1;
               if (ctl.idx < twd_pkg::SLOT_W'(twd_pkg::MASK_W)) begin
                  mask_in = mask_ff
                     | (twd_pkg::MASK_W'(1) << ctl.idx[twd_pkg::MASK_IDX_W-1:0]);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Clear the flags on a new request, accumulate during the scan
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         flag_ff     <= 1'b0;
         slot_out_ff <= '0;
         mask_ff     <= '0;
      end else if (ctl.scan) begin
         flag_ff     <= flag_in;
         slot_out_ff <= slot_out_in;
         mask_ff     <= mask_in;
      end
   end

   // Form the response from the gathered flags
   always_comb begin
      rsp.slot_out     = slot_out_ff;
      rsp.expired_mask = mask_ff;
      unique case (req.opcode)
         twd_pkg::OP_CREATE: rsp.status = !flag_ff;
         twd_pkg::OP_DELETE: rsp.status = 1'b0;
         twd_pkg::OP_ENTER:  rsp.status = !flag_ff;
         twd_pkg::OP_EXIT:   rsp.status = !flag_ff;
         twd_pkg::OP_CHECK:  rsp.status = flag_ff;
         default:            rsp.status = 1'b1;
      endcase
   end

endmodule
